[rtl/descriptor_free_list_defines.svh]
// assertion macros used by the back end (dfl_back) of the descriptor free list rtl
`ifndef DESCRIPTOR_FREE_LIST_DEFINES_SVH
`define DESCRIPTOR_FREE_LIST_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define DFL_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition must hold in the cycle after the trigger
`define DFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dfl_pkg.sv]
// types and codes shared by the descriptor free list modules
package dfl_pkg;

   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE       = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE_CHAIN = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_LINK       = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERLONG = 2'd2;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ALLOC,
      OP_FREE,
      OP_FREE_CHAIN,
      OP_LINK
   } dfl_op_type;

   typedef struct packed {
      dfl_op_type         op;
      logic [INDEX_W-1:0] entry_index;
      logic [INDEX_W-1:0] link_target;
      logic               link_chained;
   } dfl_cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ALLOC,
      BK_MEASURE,
      BK_PUSH
   } dfl_back_state_type;

endpackage

[rtl/descriptor_free_list.sv]
// descriptor free list: allocate, free, link and free-chain over a descriptor table
// The block keeps NUM_ENTRIES descriptors on a singly linked free list, each entry
// holding a next index and a chained flag in on-chip memory. Requests enter a
// two-entry command queue in the front, which turns indexes outside the table into
// no-ops; the back executes one command at a time against the table memories and
// parks each result in an output register, so the request side keeps filling the
// queue while a result waits. Every request yields exactly one result. The back has a
// single read port with registered read data: free, link and ignored requests are
// done in the idle state, allocate reads the list head before taking it (an empty
// list is answered without a read), and free-chain makes one pass measuring the
// chain and one pass pushing it; a chain that has not ended after NUM_ENTRIES
// entries reports an overlong error with the table untouched. The front queue
// registers each command before the back sees it. After reset the back runs a
// clearing pass over all NUM_ENTRIES entries that builds the initial list, and
// req_stall stays high until it finishes.
module descriptor_free_list import dfl_pkg::*; #(
   parameter int NUM_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [INDEX_W-1:0]  req_link_target,
   input  logic                req_link_chained,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_granted_index,
   output logic [COUNT_W-1:0]  rsp_freed_count
);

   // front to back command transfer
   logic        cmd_valid;
   logic        cmd_pop;
   dfl_cmd_type cmd;
   // back is building the initial list
   logic        back_clearing;

   // decode and queue, one transfer per cycle when not full and the back is not clearing
   dfl_front #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_entry_index  (req_entry_index),
      .req_link_target  (req_link_target),
      .req_link_chained (req_link_chained),
      .back_clearing    (back_clearing),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   // table memories and list walker; pops a command only when the result slot is free
   dfl_back #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .back_clearing     (back_clearing),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_freed_count   (rsp_freed_count)
   );

endmodule

[rtl/dfl_front.sv]
// request decode and command queue of the descriptor free list
module dfl_front import dfl_pkg::*; #(
   parameter int NUM_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [INDEX_W-1:0] req_link_target,
   input  logic               req_link_chained,
   input  logic               back_clearing,
   output logic               cmd_valid,
   output dfl_cmd_type        cmd,
   input  logic               cmd_pop
);

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int FILL_W = $clog2(QDEPTH + 1);

   dfl_cmd_type       q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   dfl_cmd_type       cmd_new;
   logic              idx_ok;
   logic              push;

   // classify: out-of-table indexes become no-ops
   always_comb begin
      idx_ok = 32'(req_entry_index) < NUM_ENTRIES;
      cmd_new.entry_index  = req_entry_index;
      cmd_new.link_target  = req_link_target;
      cmd_new.link_chained = req_link_chained;
      case (req_func)
         FUNC_ALLOC:      cmd_new.op = OP_ALLOC;
         FUNC_FREE:       cmd_new.op = idx_ok ? OP_FREE : OP_NOP;
         FUNC_FREE_CHAIN: cmd_new.op = idx_ok ? OP_FREE_CHAIN : OP_NOP;
         FUNC_LINK:       cmd_new.op = idx_ok ? OP_LINK : OP_NOP;
         default:         cmd_new.op = OP_NOP;
      endcase
   end

   always_comb begin
      req_stall = (fill_ff == FILL_W'(QDEPTH)) || back_clearing;
      push      = req_valid && !req_stall;
      cmd_valid = fill_ff != '0;
      cmd       = q_ff[rd_ptr_ff];
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push) - FILL_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

[rtl/dfl_back.sv]
// table memories, list walker and result register of the descriptor free list
`include "descriptor_free_list_defines.svh"

module dfl_back import dfl_pkg::*; #(
   parameter int NUM_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  dfl_cmd_type         cmd,
   output logic                cmd_pop,
   output logic                back_clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_granted_index,
   output logic [COUNT_W-1:0]  rsp_freed_count
);

   localparam int AW = $clog2(NUM_ENTRIES);
   localparam int LW = AW + 1;
   localparam logic [LW-1:0] LIMIT = LW'(NUM_ENTRIES);

   logic [LW-1:0] link_mem [NUM_ENTRIES];
   logic          mark_mem [NUM_ENTRIES];

   dfl_back_state_type  state_ff, state_in;
   logic [LW-1:0]       free_head_ff, free_head_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [AW-1:0]       start_ff, start_in;
   logic [LW-1:0]       count_ff, count_in;
   logic [LW-1:0]       len_ff, len_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic [COUNT_W-1:0]  rsp_freed_ff, rsp_freed_in;

   logic [LW-1:0] rd_link_ff;
   logic          rd_mark_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          link_we, mark_we;
   logic [LW-1:0] link_wdata;
   logic          mark_wdata;
   logic [AW-1:0] cmd_idx;
   logic [LW-1:0] target_sat;
   logic [AW-1:0] nxt;
   logic          slot_free;

   always_comb begin
      cmd_idx    = AW'(cmd.entry_index);
      // targets past the table all mean end of list
      target_sat = (32'(cmd.link_target) >= NUM_ENTRIES) ? LIMIT : LW'(cmd.link_target);
      nxt        = (rd_link_ff >= LIMIT) ? '0 : rd_link_ff[AW-1:0];
      slot_free  = !rsp_valid_ff || !rsp_stall;

      state_in       = state_ff;
      free_head_in   = free_head_ff;
      clr_in         = clr_ff;
      cur_in         = cur_ff;
      start_in       = start_ff;
      count_in       = count_ff;
      len_in         = len_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_freed_in   = rsp_freed_ff;
      rd_addr        = cur_ff;
      wr_addr        = cur_ff;
      link_we        = 1'b0;
      mark_we        = 1'b0;
      link_wdata     = free_head_ff;
      mark_wdata     = 1'b0;
      cmd_pop        = 1'b0;
      back_clearing  = 1'b0;

      case (state_ff)
         BK_CLEAR: begin
            back_clearing = 1'b1;
            wr_addr       = clr_ff;
            link_we       = 1'b1;
            mark_we       = 1'b1;
            link_wdata    = LW'(clr_ff) + LW'(1);
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == AW'(NUM_ENTRIES - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_ALLOC: begin
                     if (free_head_ff >= LIMIT) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = STATUS_EMPTY;
                        rsp_granted_in = '0;
                        rsp_freed_in   = '0;
                     end else begin
                        rd_addr  = free_head_ff[AW-1:0];
                        cur_in   = free_head_ff[AW-1:0];
                        state_in = BK_ALLOC;
                     end
                  end
                  OP_FREE: begin
                     wr_addr        = cmd_idx;
                     link_we        = 1'b1;
                     link_wdata     = free_head_ff;
                     free_head_in   = LW'(cmd_idx);
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = STATUS_OK;
                     rsp_granted_in = '0;
                     rsp_freed_in   = COUNT_W'(1);
                  end
                  OP_LINK: begin
                     wr_addr        = cmd_idx;
                     link_we        = 1'b1;
                     mark_we        = 1'b1;
                     link_wdata     = target_sat;
                     mark_wdata     = cmd.link_chained;
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = STATUS_OK;
                     rsp_granted_in = '0;
                     rsp_freed_in   = '0;
                  end
                  OP_FREE_CHAIN: begin
                     rd_addr  = cmd_idx;
                     cur_in   = cmd_idx;
                     start_in = cmd_idx;
                     count_in = LW'(1);
                     state_in = BK_MEASURE;
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = STATUS_OK;
                     rsp_granted_in = '0;
                     rsp_freed_in   = '0;
                  end
               endcase
            end
         end
         BK_ALLOC: begin
            free_head_in   = rd_link_ff;
            wr_addr        = cur_ff;
            mark_we        = 1'b1;
            mark_wdata     = 1'b0;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_OK;
            rsp_granted_in = INDEX_W'(cur_ff);
            rsp_freed_in   = '0;
            state_in       = BK_IDLE;
         end
         BK_MEASURE: begin
            if (!rd_mark_ff || rd_link_ff >= LIMIT) begin
               len_in   = count_ff;
               count_in = '0;
               rd_addr  = start_ff;
               cur_in   = start_ff;
               state_in = BK_PUSH;
            end else if (count_ff == LIMIT) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_OVERLONG;
               rsp_granted_in = '0;
               rsp_freed_in   = '0;
               state_in       = BK_IDLE;
            end else begin
               rd_addr  = rd_link_ff[AW-1:0];
               cur_in   = rd_link_ff[AW-1:0];
               count_in = count_ff + LW'(1);
            end
         end
         BK_PUSH: begin
            wr_addr      = cur_ff;
            link_we      = 1'b1;
            link_wdata   = free_head_ff;
            free_head_in = LW'(cur_ff);
            rd_addr      = nxt;
            cur_in       = nxt;
            count_in     = count_ff + LW'(1);
            if (count_ff + LW'(1) == len_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_granted_in = '0;
               rsp_freed_in   = COUNT_W'(len_ff);
               state_in       = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         free_head_ff <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      start_ff       <= start_in;
      count_ff       <= count_in;
      len_ff         <= len_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_freed_ff   <= rsp_freed_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[wr_addr] <= link_wdata;
      end
      if (mark_we) begin
         mark_mem[wr_addr] <= mark_wdata;
      end
      rd_link_ff <= link_mem[rd_addr];
      rd_mark_ff <= mark_mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_freed_count   = rsp_freed_ff;

   `DFL_ASSERT_IMPLIES(a_head_range, clock, reset, 1'b1, free_head_ff <= LIMIT,
                       "free head past end marker")
   `DFL_ASSERT_IMPLIES(a_walk_bound, clock, reset, state_ff == BK_MEASURE,
                       count_ff != '0 && count_ff <= LIMIT, "chain walk count out of range")
   `DFL_ASSERT_IMPLIES(a_push_bound, clock, reset, state_ff == BK_PUSH, count_ff < len_ff,
                       "push pass overran chain length")
   `DFL_ASSERT_NEXT(a_pop_progress, clock, reset, cmd_pop,
                    rsp_valid_ff || state_ff != BK_IDLE, "popped command produced no work")

endmodule
